// File: hw/rtl/rrts_pkg.sv
// package for the round robin task scheduler core
// widths, mode/status/error codes, datapath command codes and shared types
// no dependencies
`default_nettype none

package rrts_pkg;

    localparam int ID_W          = 7;
    localparam int PRIO_W        = 8;
    localparam int MODE_W        = 3;
    localparam int KIND_W        = 2;
    localparam int ERR_W         = 3;
    localparam int ST_W          = 3;
    localparam int DEF_MAX_TASKS = 64;

    localparam logic [ID_W-1:0] IDLE_ID_RESET = 7'd3;

    localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PREEMPT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BLOCK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_UNBLOCK = 3'd3;
    localparam logic [MODE_W-1:0] MODE_EXIT    = 3'd4;

    localparam logic [KIND_W-1:0] KIND_WAITING = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HANGING = 2'd2;

    localparam logic [ST_W-1:0] ST_RUNNING = 3'd0;
    localparam logic [ST_W-1:0] ST_READY   = 3'd1;
    localparam logic [ST_W-1:0] ST_BLOCKED = 3'd2;
    localparam logic [ST_W-1:0] ST_WAITING = 3'd3;
    localparam logic [ST_W-1:0] ST_HANGING = 3'd4;
    localparam logic [ST_W-1:0] ST_DIED    = 3'd5;

    localparam logic [ERR_W-1:0] ERR_OK         = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NO_FREE    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_NOT_WAIT   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN    = 3'd3;
    localparam logic [ERR_W-1:0] ERR_NO_RUNNING = 3'd4;

    typedef logic [4:0] t_op;

    localparam t_op OP_NOP      = 5'd0;
    localparam t_op OP_LATCH    = 5'd1;
    localparam t_op OP_RD_TID   = 5'd2;
    localparam t_op OP_ERR      = 5'd3;
    localparam t_op OP_CREATE   = 5'd4;
    localparam t_op OP_BLOCK    = 5'd5;
    localparam t_op OP_UNBLK    = 5'd6;
    localparam t_op OP_EXIT     = 5'd7;
    localparam t_op OP_APP1     = 5'd8;
    localparam t_op OP_APP2     = 5'd9;
    localparam t_op OP_PUSH1    = 5'd10;
    localparam t_op OP_PUSH2    = 5'd11;
    localparam t_op OP_REM1     = 5'd12;
    localparam t_op OP_REM2     = 5'd13;
    localparam t_op OP_SCH_CUR  = 5'd14;
    localparam t_op OP_RD_IDLE  = 5'd15;
    localparam t_op OP_SCH_IDLE = 5'd16;
    localparam t_op OP_PICK     = 5'd17;
    localparam t_op OP_NONE_RUN = 5'd18;
    localparam t_op OP_RD_PRIO  = 5'd19;

    typedef struct packed {
        t_op              op;
        logic [ERR_W-1:0] err;
    } t_cmd;

    typedef struct packed {
        logic cur_valid;
        logic head_valid;
        logic free_ok;
        logic create_run;
        logic tid_used;
        logic tid_ready;
        logic tid_waiting;
        logic idle_waiting;
    } t_stat;

    function automatic logic id_ok(input logic [ID_W-1:0] id, input int max_ids);
        return (id != '0) && (int'(id) <= max_ids);
    endfunction

    function automatic logic st_is_waiting(input logic [ST_W-1:0] st);
        return (st == ST_BLOCKED) || (st == ST_WAITING) || (st == ST_HANGING);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rrts_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module rrts_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [W-1:0]             i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rrts_datapath.sv
// scheduler datapath: queue pointers, id allocator, task tables in rams
// depends on rrts_pkg and rrts_ram
`default_nettype none

module rrts_datapath import rrts_pkg::*; #(
    parameter int MAX_TASKS = DEF_MAX_TASKS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [ID_W-1:0]   i_cfg_wdata,
    input  wire logic [ID_W-1:0]   i_task_id,
    input  wire logic [PRIO_W-1:0] i_priority_req,
    input  wire logic [KIND_W-1:0] i_block_kind,
    input  wire logic              i_create_running,
    input  wire t_cmd              i_cmd,
    output t_stat                  o_stat,
    output logic [ID_W-1:0]        o_new_id,
    output logic [ID_W-1:0]        o_running_id,
    output logic [PRIO_W-1:0]      o_running_slice,
    output logic                   o_switched,
    output logic [ERR_W-1:0]       o_error
);

    localparam int AW = $clog2(MAX_TASKS);

    function automatic logic [AW-1:0] slot(input logic [ID_W-1:0] id);
        return AW'(id - ID_W'(1));
    endfunction

    logic [ID_W-1:0]      r_idle, n_idle;
    logic [ID_W-1:0]      r_head, n_head;
    logic [ID_W-1:0]      r_tail, n_tail;
    logic [ID_W-1:0]      r_cur, n_cur;
    logic [ID_W-1:0]      r_id, n_id;
    logic [MAX_TASKS-1:0] r_used, n_used;
    logic [ID_W-1:0]      r_tid, n_tid;
    logic [PRIO_W-1:0]    r_prio, n_prio;
    logic [KIND_W-1:0]    r_kind, n_kind;
    logic                 r_mkrun, n_mkrun;
    logic [ID_W-1:0]      r_new_id, n_new_id;
    logic                 r_sw, n_sw;
    logic [ERR_W-1:0]     r_err, n_err;

    logic              st_we, st_re, pr_we, pr_re, nx_we, nx_re, pv_we, pv_re;
    logic [AW-1:0]     st_waddr, st_raddr, pr_waddr, pr_raddr;
    logic [AW-1:0]     nx_waddr, nx_raddr, pv_waddr, pv_raddr;
    logic [ST_W-1:0]   st_wdata, st_rdata;
    logic [PRIO_W-1:0] pr_rdata;
    logic [ID_W-1:0]   nx_wdata, nx_rdata, pv_wdata, pv_rdata;

    logic [AW-1:0]   alloc;
    logic            free_ok;
    logic [ID_W-1:0] alloc_id;
    logic            cur_valid, head_valid, tail_valid, create_run;
    logic [ST_W-1:0] kind_st;

    always_comb begin
        alloc   = '0;
        free_ok = 1'b0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                alloc   = AW'(i);
                free_ok = 1'b1;
            end
        end
    end

    assign alloc_id   = ID_W'(alloc) + ID_W'(1);
    assign cur_valid  = id_ok(r_cur, MAX_TASKS);
    assign head_valid = id_ok(r_head, MAX_TASKS);
    assign tail_valid = id_ok(r_tail, MAX_TASKS);
    assign create_run = r_mkrun && !cur_valid;

    always_comb begin
        case (r_kind)
            KIND_WAITING: kind_st = ST_WAITING;
            KIND_HANGING: kind_st = ST_HANGING;
            default:      kind_st = ST_BLOCKED;
        endcase
    end

    always_comb begin
        o_stat.cur_valid    = cur_valid;
        o_stat.head_valid   = head_valid;
        o_stat.free_ok      = free_ok;
        o_stat.create_run   = create_run;
        o_stat.tid_used     = id_ok(r_tid, MAX_TASKS) && r_used[slot(r_tid)];
        o_stat.tid_ready    = (st_rdata == ST_READY);
        o_stat.tid_waiting  = st_is_waiting(st_rdata);
        o_stat.idle_waiting = id_ok(r_idle, MAX_TASKS) && r_used[slot(r_idle)]
                              && st_is_waiting(st_rdata);
    end

    always_comb begin
        n_idle   = i_cfg_we ? i_cfg_wdata : r_idle;
        n_head   = r_head;
        n_tail   = r_tail;
        n_cur    = r_cur;
        n_id     = r_id;
        n_used   = r_used;
        n_tid    = r_tid;
        n_prio   = r_prio;
        n_kind   = r_kind;
        n_mkrun  = r_mkrun;
        n_new_id = r_new_id;
        n_sw     = r_sw;
        n_err    = r_err;
        st_we = 1'b0; st_waddr = '0; st_wdata = ST_RUNNING;
        st_re = 1'b0; st_raddr = '0;
        pr_we = 1'b0; pr_waddr = '0;
        pr_re = 1'b0; pr_raddr = '0;
        nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0;
        nx_re = 1'b0; nx_raddr = '0;
        pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0;
        pv_re = 1'b0; pv_raddr = '0;
        unique case (i_cmd.op)
            OP_LATCH: begin
                n_tid    = i_task_id;
                n_prio   = i_priority_req;
                n_kind   = i_block_kind;
                n_mkrun  = i_create_running;
                n_new_id = '0;
                n_sw     = 1'b0;
                n_err    = ERR_OK;
            end
            OP_RD_TID: begin
                st_re    = 1'b1;
                st_raddr = slot(r_tid);
            end
            OP_ERR: begin
                n_err = i_cmd.err;
            end
            OP_CREATE: begin
                n_used[alloc] = 1'b1;
                pr_we    = 1'b1;
                pr_waddr = alloc;
                st_we    = 1'b1;
                st_waddr = alloc;
                st_wdata = create_run ? ST_RUNNING : ST_READY;
                n_new_id = alloc_id;
                n_id     = alloc_id;
                if (create_run) begin
                    n_cur = alloc_id;
                    n_sw  = 1'b1;
                end
            end
            OP_BLOCK: begin
                st_we    = 1'b1;
                st_waddr = slot(r_cur);
                st_wdata = kind_st;
            end
            OP_UNBLK: begin
                st_we    = 1'b1;
                st_waddr = slot(r_tid);
                st_wdata = ST_READY;
                n_id     = r_tid;
            end
            OP_EXIT: begin
                st_we    = 1'b1;
                st_waddr = slot(r_tid);
                st_wdata = ST_DIED;
                n_used[slot(r_tid)] = 1'b0;
                n_id     = r_tid;
                if (r_cur == r_tid) begin
                    n_cur = '0;
                end
            end
            OP_APP1: begin
                nx_we    = 1'b1;
                nx_waddr = slot(r_id);
                nx_wdata = '0;
                pv_we    = 1'b1;
                pv_waddr = slot(r_id);
                pv_wdata = r_tail;
            end
            OP_APP2: begin
                if (tail_valid) begin
                    nx_we    = 1'b1;
                    nx_waddr = slot(r_tail);
                    nx_wdata = r_id;
                end else begin
                    n_head = r_id;
                end
                n_tail = r_id;
            end
            OP_PUSH1: begin
                pv_we    = 1'b1;
                pv_waddr = slot(r_id);
                pv_wdata = '0;
                nx_we    = 1'b1;
                nx_waddr = slot(r_id);
                nx_wdata = r_head;
            end
            OP_PUSH2: begin
                if (head_valid) begin
                    pv_we    = 1'b1;
                    pv_waddr = slot(r_head);
                    pv_wdata = r_id;
                end else begin
                    n_tail = r_id;
                end
                n_head = r_id;
            end
            OP_REM1: begin
                nx_re    = 1'b1;
                nx_raddr = slot(r_id);
                pv_re    = 1'b1;
                pv_raddr = slot(r_id);
            end
            OP_REM2: begin
                if (id_ok(pv_rdata, MAX_TASKS)) begin
                    nx_we    = 1'b1;
                    nx_waddr = slot(pv_rdata);
                    nx_wdata = nx_rdata;
                end else begin
                    n_head = nx_rdata;
                end
                if (id_ok(nx_rdata, MAX_TASKS)) begin
                    pv_we    = 1'b1;
                    pv_waddr = slot(nx_rdata);
                    pv_wdata = pv_rdata;
                end else begin
                    n_tail = pv_rdata;
                end
            end
            OP_SCH_CUR: begin
                st_we    = 1'b1;
                st_waddr = slot(r_cur);
                st_wdata = ST_READY;
                n_id     = r_cur;
            end
            OP_RD_IDLE: begin
                st_re    = 1'b1;
                st_raddr = slot(r_idle);
            end
            OP_SCH_IDLE: begin
                st_we    = 1'b1;
                st_waddr = slot(r_idle);
                st_wdata = ST_READY;
                n_id     = r_idle;
            end
            OP_PICK: begin
                st_we    = 1'b1;
                st_waddr = slot(r_head);
                st_wdata = ST_RUNNING;
                n_id     = r_head;
                n_cur    = r_head;
                n_sw     = 1'b1;
            end
            OP_NONE_RUN: begin
                n_cur = '0;
            end
            OP_RD_PRIO: begin
                pr_re    = 1'b1;
                pr_raddr = slot(r_cur);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle <= IDLE_ID_RESET;
            r_head <= '0;
            r_tail <= '0;
            r_cur  <= '0;
            r_used <= '0;
        end else begin
            r_idle <= n_idle;
            r_head <= n_head;
            r_tail <= n_tail;
            r_cur  <= n_cur;
            r_used <= n_used;
        end
        r_id     <= n_id;
        r_tid    <= n_tid;
        r_prio   <= n_prio;
        r_kind   <= n_kind;
        r_mkrun  <= n_mkrun;
        r_new_id <= n_new_id;
        r_sw     <= n_sw;
        r_err    <= n_err;
    end

    rrts_ram #(.W(ST_W), .DEPTH(MAX_TASKS)) u_status (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_re(st_re), .i_raddr(st_raddr), .o_rdata(st_rdata)
    );

    rrts_ram #(.W(PRIO_W), .DEPTH(MAX_TASKS)) u_prio (
        .i_clk(i_clk), .i_we(pr_we), .i_waddr(pr_waddr), .i_wdata(r_prio),
        .i_re(pr_re), .i_raddr(pr_raddr), .o_rdata(pr_rdata)
    );

    rrts_ram #(.W(ID_W), .DEPTH(MAX_TASKS)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_re(nx_re), .i_raddr(nx_raddr), .o_rdata(nx_rdata)
    );

    rrts_ram #(.W(ID_W), .DEPTH(MAX_TASKS)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_waddr), .i_wdata(pv_wdata),
        .i_re(pv_re), .i_raddr(pv_raddr), .o_rdata(pv_rdata)
    );

    assign o_new_id        = r_new_id;
    assign o_running_id    = r_cur;
    assign o_running_slice = cur_valid ? pr_rdata : '0;
    assign o_switched      = r_sw;
    assign o_error         = r_err;

endmodule

`default_nettype wire

// File: hw/rtl/rrts_ctrl.sv
// scheduler controller: sequences queue and table operations per event
// depends on rrts_pkg
`default_nettype none

module rrts_ctrl import rrts_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic              i_reschedule,
    input  wire t_stat             i_stat,
    output t_cmd                   o_cmd,
    output logic                   busy,
    output logic                   o_done
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDST  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_APP1  = 4'd3;
    localparam logic [3:0] S_APP2  = 4'd4;
    localparam logic [3:0] S_PUSH1 = 4'd5;
    localparam logic [3:0] S_PUSH2 = 4'd6;
    localparam logic [3:0] S_REM1  = 4'd7;
    localparam logic [3:0] S_REM2  = 4'd8;
    localparam logic [3:0] S_EXIT2 = 4'd9;
    localparam logic [3:0] S_SCH0  = 4'd10;
    localparam logic [3:0] S_SCH1  = 4'd11;
    localparam logic [3:0] S_SCH2  = 4'd12;
    localparam logic [3:0] S_SCH3  = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    logic [3:0]        r_state, n_state;
    logic [3:0]        r_ret, n_ret;
    logic [MODE_W-1:0] r_mode, n_mode;
    logic              r_resched, n_resched;

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_mode    = r_mode;
        n_resched = r_resched;
        o_cmd.op  = OP_NOP;
        o_cmd.err = ERR_OK;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.op  = OP_LATCH;
                    n_mode    = i_mode;
                    n_resched = i_reschedule;
                    n_state   = S_RDST;
                end
            end
            S_RDST: begin
                o_cmd.op = OP_RD_TID;
                n_state  = S_DISP;
            end
            S_DISP: begin
                n_state = S_DONE;
                case (r_mode)
                    MODE_CREATE: begin
                        if (!i_stat.free_ok) begin
                            o_cmd.op  = OP_ERR;
                            o_cmd.err = ERR_NO_FREE;
                        end else begin
                            o_cmd.op = OP_CREATE;
                            if (!i_stat.create_run) begin
                                n_ret   = S_DONE;
                                n_state = S_APP1;
                            end
                        end
                    end
                    MODE_PREEMPT, MODE_BLOCK: begin
                        if (!i_stat.cur_valid) begin
                            o_cmd.op  = OP_ERR;
                            o_cmd.err = ERR_NO_RUNNING;
                        end else begin
                            if (r_mode == MODE_BLOCK) begin
                                o_cmd.op = OP_BLOCK;
                            end
                            n_state = S_SCH0;
                        end
                    end
                    MODE_UNBLOCK: begin
                        if (!i_stat.tid_used) begin
                            o_cmd.op  = OP_ERR;
                            o_cmd.err = ERR_UNKNOWN;
                        end else if (!i_stat.tid_waiting) begin
                            o_cmd.op  = OP_ERR;
                            o_cmd.err = ERR_NOT_WAIT;
                        end else begin
                            o_cmd.op = OP_UNBLK;
                            n_ret    = S_DONE;
                            n_state  = S_PUSH1;
                        end
                    end
                    MODE_EXIT: begin
                        if (!i_stat.tid_used) begin
                            o_cmd.op  = OP_ERR;
                            o_cmd.err = ERR_UNKNOWN;
                        end else begin
                            o_cmd.op = OP_EXIT;
                            if (i_stat.tid_ready) begin
                                n_ret   = S_EXIT2;
                                n_state = S_REM1;
                            end else begin
                                n_state = S_EXIT2;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_APP1: begin
                o_cmd.op = OP_APP1;
                n_state  = S_APP2;
            end
            S_APP2: begin
                o_cmd.op = OP_APP2;
                n_state  = r_ret;
            end
            S_PUSH1: begin
                o_cmd.op = OP_PUSH1;
                n_state  = S_PUSH2;
            end
            S_PUSH2: begin
                o_cmd.op = OP_PUSH2;
                n_state  = r_ret;
            end
            S_REM1: begin
                o_cmd.op = OP_REM1;
                n_state  = S_REM2;
            end
            S_REM2: begin
                o_cmd.op = OP_REM2;
                n_state  = r_ret;
            end
            S_EXIT2: begin
                n_state = r_resched ? S_SCH0 : S_DONE;
            end
            S_SCH0: begin
                if (i_stat.cur_valid && (r_mode != MODE_BLOCK)) begin
                    o_cmd.op = OP_SCH_CUR;
                    n_ret    = S_SCH1;
                    n_state  = S_APP1;
                end else begin
                    n_state = S_SCH1;
                end
            end
            S_SCH1: begin
                o_cmd.op = OP_RD_IDLE;
                n_state  = S_SCH2;
            end
            S_SCH2: begin
                if (!i_stat.head_valid && i_stat.idle_waiting) begin
                    o_cmd.op = OP_SCH_IDLE;
                    n_ret    = S_SCH3;
                    n_state  = S_PUSH1;
                end else begin
                    n_state = S_SCH3;
                end
            end
            S_SCH3: begin
                if (i_stat.head_valid) begin
                    o_cmd.op = OP_PICK;
                    n_ret    = S_DONE;
                    n_state  = S_REM1;
                end else begin
                    o_cmd.op = OP_NONE_RUN;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.op = OP_RD_PRIO;
                n_state  = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_ret     <= n_ret;
        r_mode    <= n_mode;
        r_resched <= n_resched;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_OUT);

endmodule

`default_nettype wire

// File: hw/rtl/round_robin_task_scheduler_core.sv
// round robin ready queue task scheduler with id allocator
// one event at a time; o_done rises once the controller has walked the
// single write, single read port link rams for that event
// busy stays high until the cycle after the o_done strobe; results cannot be stalled
// synchronous active low reset empties the queue, frees all ids, idle id 3
// depends on rrts_pkg, rrts_ctrl, rrts_datapath
`default_nettype none

module round_robin_task_scheduler_core import rrts_pkg::*; #(
    parameter int MAX_TASKS = DEF_MAX_TASKS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [ID_W-1:0]   i_cfg_wdata,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic [ID_W-1:0]   i_task_id,
    input  wire logic [PRIO_W-1:0] i_priority_req,
    input  wire logic [KIND_W-1:0] i_block_kind,
    input  wire logic              i_create_running,
    input  wire logic              i_reschedule,
    output logic                   o_done,
    output logic [ID_W-1:0]        o_new_id,
    output logic [ID_W-1:0]        o_running_id,
    output logic [PRIO_W-1:0]      o_running_slice,
    output logic                   o_switched,
    output logic [ERR_W-1:0]       o_error
);

    t_cmd  cmd;
    t_stat stat;

    rrts_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_mode       (i_mode),
        .i_reschedule (i_reschedule),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .busy         (busy),
        .o_done       (o_done)
    );

    rrts_datapath #(.MAX_TASKS(MAX_TASKS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_task_id        (i_task_id),
        .i_priority_req   (i_priority_req),
        .i_block_kind     (i_block_kind),
        .i_create_running (i_create_running),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_new_id         (o_new_id),
        .o_running_id     (o_running_id),
        .o_running_slice  (o_running_slice),
        .o_switched       (o_switched),
        .o_error          (o_error)
    );

endmodule

`default_nettype wire

// File: hw/rtl/rrts_checker.sv
// port level checks for the task scheduler core, bound to the top level
// depends on rrts_pkg
`default_nettype none

module rrts_checker import rrts_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              o_done,
    input wire logic [ID_W-1:0]   o_new_id,
    input wire logic [ID_W-1:0]   o_running_id,
    input wire logic [PRIO_W-1:0] o_running_slice,
    input wire logic              o_switched,
    input wire logic [ERR_W-1:0]  o_error
);

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after start transfer");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !busy))
        else $error("result strobe longer than one cycle");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result without an event in flight");

    a_none_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_running_id == '0)) |-> ((o_running_slice == '0) && !o_switched))
        else $error("slice or switch with no running task");

    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_error != ERR_OK)) |-> ((o_new_id == '0) && !o_switched))
        else $error("error result with side effects");

endmodule

bind round_robin_task_scheduler_core rrts_checker u_rrts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_new_id        (o_new_id),
    .o_running_id    (o_running_id),
    .o_running_slice (o_running_slice),
    .o_switched      (o_switched),
    .o_error         (o_error)
);

`default_nettype wire

// File: sim/rrts_checker.sv
// scoreboard for the round robin task scheduler core: watches start transfers,
// predicts each result with its own scheduler state and compares on o_done
// depends on rrts_pkg
`default_nettype none

module rrts_scoreboard import rrts_pkg::*; #(
    parameter int MAX_TASKS = DEF_MAX_TASKS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [ID_W-1:0]   i_cfg_wdata,
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic [ID_W-1:0]   i_task_id,
    input  wire logic [PRIO_W-1:0] i_priority_req,
    input  wire logic [KIND_W-1:0] i_block_kind,
    input  wire logic              i_create_running,
    input  wire logic              i_reschedule,
    input  wire logic              i_done,
    input  wire logic [ID_W-1:0]   i_new_id,
    input  wire logic [ID_W-1:0]   i_running_id,
    input  wire logic [PRIO_W-1:0] i_running_slice,
    input  wire logic              i_switched,
    input  wire logic [ERR_W-1:0]  i_error,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_results_seen,
    output int                     o_live_tasks,
    output int                     o_current
);

    typedef struct packed {
        logic [ID_W-1:0]   new_id;
        logic [ID_W-1:0]   running_id;
        logic [PRIO_W-1:0] running_slice;
        logic              switched;
        logic [ERR_W-1:0]  error;
    } t_sched_result;

    t_sched_result   expected_results[$];
    logic            used_tbl[MAX_TASKS];
    logic [ST_W-1:0] status_tbl[MAX_TASKS];
    logic [PRIO_W-1:0] prio_tbl[MAX_TASKS];
    logic [ID_W-1:0] next_tbl[MAX_TASKS];
    logic [ID_W-1:0] prev_tbl[MAX_TASKS];
    logic [ID_W-1:0] head_id, tail_id, cur_id, idle_id;

    function automatic bit id_valid(input logic [ID_W-1:0] id);
        return id >= 1 && int'(id) <= MAX_TASKS;
    endfunction

    task automatic ready_append(input logic [ID_W-1:0] id);
        next_tbl[id-1] = '0;
        prev_tbl[id-1] = tail_id;
        if (id_valid(tail_id)) next_tbl[tail_id-1] = id;
        else head_id = id;
        tail_id = id;
    endtask

    task automatic ready_push(input logic [ID_W-1:0] id);
        prev_tbl[id-1] = '0;
        next_tbl[id-1] = head_id;
        if (id_valid(head_id)) prev_tbl[head_id-1] = id;
        else tail_id = id;
        head_id = id;
    endtask

    task automatic ready_unlink(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] p, n;
        p = prev_tbl[id-1];
        n = next_tbl[id-1];
        if (id_valid(p)) next_tbl[p-1] = n;
        else head_id = n;
        if (id_valid(n)) prev_tbl[n-1] = p;
        else tail_id = p;
    endtask

    function automatic bit is_parked(input logic [ID_W-1:0] id);
        if (!id_valid(id) || !used_tbl[id-1]) return 0;
        return st_is_waiting(status_tbl[id-1]);
    endfunction

    task automatic pick_next(output logic sw);
        logic [ID_W-1:0] nxt;
        if (id_valid(cur_id) && status_tbl[cur_id-1] == ST_RUNNING) begin
            ready_append(cur_id);
            status_tbl[cur_id-1] = ST_READY;
        end
        if (!id_valid(head_id) && is_parked(idle_id)) begin
            ready_push(idle_id);
            status_tbl[idle_id-1] = ST_READY;
        end
        nxt = head_id;
        sw = 0;
        cur_id = '0;
        if (id_valid(nxt)) begin
            ready_unlink(nxt);
            status_tbl[nxt-1] = ST_RUNNING;
            cur_id = nxt;
            sw = 1;
        end
    endtask

    task automatic predict_event(output t_sched_result r);
        int slot;
        logic sw;
        r = '0;
        sw = 0;
        case (i_mode)
            MODE_CREATE: begin
                slot = MAX_TASKS;
                for (int k = MAX_TASKS - 1; k >= 0; k--) if (!used_tbl[k]) slot = k;
                if (slot == MAX_TASKS) r.error = ERR_NO_FREE;
                else begin
                    r.new_id = ID_W'(slot + 1);
                    used_tbl[slot] = 1;
                    prio_tbl[slot] = i_priority_req;
                    if (i_create_running && !id_valid(cur_id)) begin
                        status_tbl[slot] = ST_RUNNING;
                        cur_id = r.new_id;
                        sw = 1;
                    end else begin
                        status_tbl[slot] = ST_READY;
                        ready_append(r.new_id);
                    end
                end
            end
            MODE_PREEMPT: begin
                if (!id_valid(cur_id)) r.error = ERR_NO_RUNNING;
                else pick_next(sw);
            end
            MODE_BLOCK: begin
                if (!id_valid(cur_id)) r.error = ERR_NO_RUNNING;
                else begin
                    status_tbl[cur_id-1] = (i_block_kind == KIND_WAITING) ? ST_WAITING :
                        (i_block_kind == KIND_HANGING) ? ST_HANGING : ST_BLOCKED;
                    pick_next(sw);
                end
            end
            MODE_UNBLOCK: begin
                if (!id_valid(i_task_id) || !used_tbl[i_task_id-1]) r.error = ERR_UNKNOWN;
                else if (!is_parked(i_task_id)) r.error = ERR_NOT_WAIT;
                else begin
                    ready_push(i_task_id);
                    status_tbl[i_task_id-1] = ST_READY;
                end
            end
            MODE_EXIT: begin
                if (!id_valid(i_task_id) || !used_tbl[i_task_id-1]) r.error = ERR_UNKNOWN;
                else begin
                    if (status_tbl[i_task_id-1] == ST_READY) ready_unlink(i_task_id);
                    status_tbl[i_task_id-1] = ST_DIED;
                    used_tbl[i_task_id-1] = 0;
                    if (cur_id == i_task_id) cur_id = '0;
                    if (i_reschedule) pick_next(sw);
                end
            end
            default: ;
        endcase
        r.switched = sw;
        r.running_id = cur_id;
        if (id_valid(cur_id)) r.running_slice = prio_tbl[cur_id-1];
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %0d: %s got %0d expected %0d", o_results_seen, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_results_seen = 0;
        for (int k = 0; k < MAX_TASKS; k++) begin
            used_tbl[k] = 0;
            status_tbl[k] = ST_RUNNING;
        end
        head_id = '0;
        tail_id = '0;
        cur_id = '0;
        idle_id = IDLE_ID_RESET;
    end

    always @(posedge i_clk) begin
        t_sched_result want, got;
        int live;
        if (i_rst_n) begin
            if (i_done) begin
                got = '{i_new_id, i_running_id, i_running_slice, i_switched, i_error};
                if (expected_results.size() == 0) report_mismatch("unexpected transfer", 1, 0);
                else begin
                    want = expected_results.pop_front();
                    if (got.new_id !== want.new_id)
                        report_mismatch("new_id", got.new_id, want.new_id);
                    if (got.running_id !== want.running_id)
                        report_mismatch("running_id", got.running_id, want.running_id);
                    if (got.running_slice !== want.running_slice)
                        report_mismatch("running_slice", got.running_slice, want.running_slice);
                    if (got.switched !== want.switched)
                        report_mismatch("switched", got.switched, want.switched);
                    if (got.error !== want.error)
                        report_mismatch("error", got.error, want.error);
                end
                o_results_seen++;
            end
            if (i_cfg_we) idle_id = i_cfg_wdata;
            if (i_start && !i_busy) begin
                predict_event(want);
                expected_results.push_back(want);
            end
        end
        live = 0;
        for (int k = 0; k < MAX_TASKS; k++) live += used_tbl[k];
        o_live_tasks <= live;
        o_current <= cur_id;
        o_pending <= expected_results.size();
    end

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// top of the scheduler regression: clock, reset, stimulus and verdict
// the scheduler core and rrts_scoreboard sit side by side; depends on rrts_pkg
`default_nettype none

module tb_top;
    import rrts_pkg::*;

    localparam int MAX_TASKS = DEF_MAX_TASKS;
    localparam int CYCLE_LIMIT = 400000;

    logic              clk, rst_n, cfg_we, start_r, busy, done;
    logic [ID_W-1:0]   cfg_wdata, task_id, new_id, running_id;
    logic [MODE_W-1:0] mode;
    logic [PRIO_W-1:0] prio, running_slice;
    logic [KIND_W-1:0] kind;
    logic              mk_run, resched, switched;
    logic [ERR_W-1:0]  error;
    int                fail_count, pending, results_seen, live_tasks, current;
    int                cycle_count, sender_idle_pct, events_sent;

    round_robin_task_scheduler_core #(.MAX_TASKS(MAX_TASKS)) dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .start(start_r), .busy(busy), .i_mode(mode), .i_task_id(task_id),
        .i_priority_req(prio), .i_block_kind(kind), .i_create_running(mk_run),
        .i_reschedule(resched), .o_done(done), .o_new_id(new_id),
        .o_running_id(running_id), .o_running_slice(running_slice),
        .o_switched(switched), .o_error(error)
    );

    rrts_scoreboard #(.MAX_TASKS(MAX_TASKS)) checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_start(start_r), .i_busy(busy), .i_mode(mode), .i_task_id(task_id),
        .i_priority_req(prio), .i_block_kind(kind), .i_create_running(mk_run),
        .i_reschedule(resched), .i_done(done), .i_new_id(new_id),
        .i_running_id(running_id), .i_running_slice(running_slice),
        .i_switched(switched), .i_error(error), .o_fail_count(fail_count),
        .o_pending(pending), .o_results_seen(results_seen),
        .o_live_tasks(live_tasks), .o_current(current)
    );

    initial begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("round_robin_task_scheduler_core regression: fail");
            $finish;
        end
    end

    task automatic send_event(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] tid,
                              input logic [PRIO_W-1:0] p, input logic [KIND_W-1:0] k,
                              input logic mr, input logic rs);
        while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
        mode <= m; task_id <= tid; prio <= p; kind <= k; mk_run <= mr; resched <= rs;
        start_r <= 1;
        @(posedge clk);
        while (busy) @(posedge clk);
        start_r <= 0;
        events_sent++;
        @(posedge clk);
    endtask

    task automatic write_idle_id(input logic [ID_W-1:0] v);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task automatic random_event();
        int pick;
        logic [ID_W-1:0] tid;
        pick = $urandom_range(99);
        tid = ($urandom_range(15) == 0) ? ID_W'($urandom_range(127))
                                        : ID_W'($urandom_range(MAX_TASKS));
        if (pick < 30 && live_tasks < 60)
            send_event(MODE_CREATE, ID_W'($urandom), PRIO_W'($urandom), KIND_W'($urandom),
                       1'($urandom), 1'($urandom));
        else if (pick < 30)
            send_event(MODE_EXIT, tid, PRIO_W'($urandom), 0, 0, 1'($urandom));
        else if (pick < 50)
            send_event(MODE_PREEMPT, tid, PRIO_W'($urandom), 0, 1'($urandom), 0);
        else if (pick < 63)
            send_event(MODE_BLOCK, tid, PRIO_W'($urandom), KIND_W'($urandom), 0, 0);
        else if (pick < 80)
            send_event(MODE_UNBLOCK, tid, PRIO_W'($urandom), 0, 0, 0);
        else if (pick < 97)
            send_event(MODE_EXIT, tid, PRIO_W'($urandom), 0, 0, 1'($urandom));
        else
            send_event(MODE_W'($urandom_range(7, 5)), tid, PRIO_W'($urandom), 0, 0, 0);
    endtask

    initial begin
        cycle_count = 0; events_sent = 0; sender_idle_pct = 0;
        rst_n = 0; cfg_we = 0; cfg_wdata = '0; start_r = 0;
        mode = '0; task_id = '0; prio = '0; kind = '0; mk_run = 0; resched = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty scheduler errors, extremes, idle task paths
        send_event(MODE_PREEMPT, 0, 0, 0, 0, 0);
        send_event(MODE_BLOCK, 0, 0, 0, 0, 0);
        send_event(MODE_UNBLOCK, 0, 0, 0, 0, 0);
        send_event(MODE_EXIT, 7'd127, 0, 0, 0, 1);
        send_event(MODE_CREATE, 0, 8'hFF, 0, 1, 0);
        send_event(MODE_CREATE, 0, 8'h00, 0, 1, 1);
        send_event(MODE_CREATE, 0, 8'h80, 0, 0, 0);
        send_event(MODE_PREEMPT, 0, 0, 0, 0, 0);
        send_event(MODE_BLOCK, 0, 0, 2'd3, 0, 0);
        send_event(MODE_BLOCK, 0, 0, KIND_WAITING, 0, 0);
        send_event(MODE_BLOCK, 0, 0, KIND_HANGING, 0, 0);
        send_event(MODE_UNBLOCK, 7'd2, 0, 0, 0, 0);
        send_event(MODE_UNBLOCK, 7'd2, 0, 0, 0, 0);
        send_event(MODE_UNBLOCK, 7'd65, 0, 0, 0, 0);
        send_event(MODE_EXIT, 7'd2, 0, 0, 0, 0);
        send_event(MODE_EXIT, 7'd1, 0, 0, 0, 1);
        send_event(3'd7, 7'h7F, 8'hFF, 2'd3, 1, 1);
        send_event(MODE_EXIT, 7'd64, 0, 0, 0, 1);
        for (int k = 0; k < 66; k++) send_event(MODE_CREATE, 0, PRIO_W'(k), 0, 1, 0);
        write_idle_id(7'd64);
        send_event(MODE_BLOCK, 0, 0, 0, 0, 0);

        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 79 : 0;
            for (int n = 0; n < 370; n++) random_event();
            write_idle_id(phase == 0 ? 7'd1 : ID_W'($urandom_range(1, MAX_TASKS)));
        end
        for (int n = 0; n < 60; n++) random_event();

        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        $display("sent %0d scheduler events, checked %0d results", events_sent, results_seen);
        $display("covered all modes, id exhaustion, idle task changes and three idle profiles");
        if (fail_count == 0)
            $display("round_robin_task_scheduler_core regression: pass");
        else
            $display("round_robin_task_scheduler_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_ram.sv
hw/rtl/rrts_datapath.sv
hw/rtl/rrts_ctrl.sv
hw/rtl/round_robin_task_scheduler_core.sv
hw/rtl/rrts_checker.sv
sim/rrts_checker.sv
sim/tb_top.sv
